// ===== rtl/p3d_pkg.sv =====
// Shared types and constants for the pseudo-3D sprite projection block.
// No dependencies; used by every module of the block.
package p3d_pkg;

    typedef struct packed {
        logic signed [15:0] object_x;
        logic        [23:0] object_depth;
        logic        [23:0] camera_depth;
    } in_t;

    typedef struct packed {
        logic               visible;
        logic signed [23:0] screen_x;
        logic        [15:0] screen_y;
        logic        [15:0] size_scale;
    } out_t;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1
    } cfg_idx_t;

    localparam int unsigned DEPTH_W    = 13;
    localparam int unsigned CORE_LAT   = 17;
    localparam logic [11:0] WIDTH_RST  = 12'd800;
    localparam logic [11:0] HEIGHT_RST = 12'd600;
    localparam logic signed [24:0] NEAR_LIMIT = 25'sd10;
    localparam logic signed [24:0] FAR_LIMIT  = 25'sd5000;
    localparam logic [18:0] SCALE_NUM  = 19'd409600;
    localparam logic [15:0] Y_SPAN_Q16 = 16'd22938;
    localparam logic [15:0] SCALE_MIN  = 16'd41;
    localparam logic [15:0] SCALE_MAX  = 16'd8192;
    localparam logic signed [24:0] X_MIN = -25'sd1600;

endpackage

// ===== rtl/p3d_div.sv =====
// Pipelined restoring divider: size_scale = (409600 + d/2) / d, one quotient bit per stage.
// Depends on p3d_pkg. The pipeline advances only while en is high.
module p3d_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [p3d_pkg::DEPTH_W-1:0]  depth,
    output logic [15:0]                  quotient
);

    logic [18:0]                 rem_reg [0:16];
    logic [p3d_pkg::DEPTH_W-1:0] dv_reg  [0:16];
    logic [15:0]                 q_reg   [0:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= p3d_pkg::SCALE_NUM + 19'(depth >> 1);
            dv_reg[0]  <= depth;
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= 16; j++)
    begin : g_stage
        localparam int K = 16 - j;
        logic [28:0] dsh;
        logic [28:0] rem_w;
        logic        take;
        assign dsh   = 29'(dv_reg[j-1]) << K;
        assign rem_w = 29'(rem_reg[j-1]);
        assign take  = rem_w >= dsh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? 19'(rem_w - dsh) : rem_reg[j-1];
                dv_reg[j]  <= dv_reg[j-1];
                q_reg[j]   <= take ? (q_reg[j-1] | (16'd1 << K)) : q_reg[j-1];
            end
        end
    end

    assign quotient = q_reg[16];

endmodule

// ===== rtl/p3d_sqrt.sv =====
// Pipelined digit-by-digit square root: largest s with 625*s*s <= d*2^29, one bit per stage.
// Depends on p3d_pkg. The pipeline advances only while en is high.
module p3d_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [p3d_pkg::DEPTH_W-1:0]  depth,
    output logic [16:0]                  root
);

    logic [45:0] r_reg [0:16];
    logic [27:0] p_reg [0:16];
    logic [16:0] s_reg [0:16];

    for (genvar j = 0; j <= 16; j++)
    begin : g_stage
        localparam int K = 16 - j;
        logic [45:0] r_in;
        logic [27:0] p_in;
        logic [16:0] s_in;
        logic [45:0] cand;
        logic        take;
        if (j == 0)
        begin : g_first
            assign r_in = 46'(depth) << 29;
            assign p_in = '0;
            assign s_in = '0;
        end
        else
        begin : g_next
            assign r_in = r_reg[j-1];
            assign p_in = p_reg[j-1];
            assign s_in = s_reg[j-1];
        end
        // p tracks 625*s, so the trial term 625*(2*s*b + b*b) needs no multiplier.
        assign cand = (46'(p_in) << (K + 1)) + (46'd625 << (2 * K));
        assign take = cand <= r_in;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j] <= take ? (r_in - cand) : r_in;
                p_reg[j] <= take ? (p_in + (28'd625 << K)) : p_in;
                s_reg[j] <= take ? (s_in | (17'd1 << K)) : s_in;
            end
        end
    end

    assign root = s_reg[16];

endmodule

// ===== rtl/pseudo3d_sprite_projection.sv =====
// Top level of the pseudo-3D sprite projection block.
// Depends on p3d_pkg, p3d_div and p3d_sqrt.
//
//   Channel  | Direction | Handshake           | Beat
//   ---------+-----------+---------------------+------------------------------
//   in       | input     | in_valid / in_stall | p3d_pkg::in_t  (object, camera)
//   out      | output    | out_valid/out_stall | p3d_pkg::out_t (screen position)
//   cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// One beat is accepted every cycle unless in_stall is high; each result passes through
// one input register, 17 stages of divider and square root, and three stages of
// multiply, scale and compare. The square-root pipeline, one result bit per stage,
// sets the depth. The whole pipeline advances together and holds when the output
// register is full and stalled, so in_stall follows out_stall while a result waits.
// Reset clears the valid bits and loads the default screen size (800 by 600).
module pseudo3d_sprite_projection (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  p3d_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output p3d_pkg::out_t  out_data,
    input  logic           cfg_write,
    input  logic [1:0]     cfg_index,
    input  logic [11:0]    cfg_data
);

    localparam int LAT = p3d_pkg::CORE_LAT;

    logic [11:0] width_reg;
    logic [11:0] height_reg;

    // Configuration must only be written while the pipeline is empty; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= p3d_pkg::WIDTH_RST;
            height_reg <= p3d_pkg::HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                p3d_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                p3d_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves unless a finished result is held at the output.
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Input stage: relative depth and the culling decision.
    logic signed [24:0] d_full;
    logic               ok_next;
    assign d_full  = $signed({1'b0, in_data.object_depth})
                   - $signed({1'b0, in_data.camera_depth});
    assign ok_next = (d_full > p3d_pkg::NEAR_LIMIT) && (d_full <= p3d_pkg::FAR_LIMIT);

    logic                         vld_a_reg;
    logic [p3d_pkg::DEPTH_W-1:0]  d_a_reg;
    logic signed [15:0]           x_a_reg;
    logic                         ok_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_a_reg <= 1'b0;
        else if (en)
            vld_a_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_a_reg  <= d_full[p3d_pkg::DEPTH_W-1:0];
            x_a_reg  <= in_data.object_x;
            ok_a_reg <= ok_next;
        end
    end

    // Divider and square root run side by side with equal latency.
    logic [15:0] scale_core;
    logic [16:0] root_core;

    p3d_div u_div (
        .clk      (clk),
        .en       (en),
        .depth    (d_a_reg),
        .quotient (scale_core)
    );

    p3d_sqrt u_sqrt (
        .clk   (clk),
        .en    (en),
        .depth (d_a_reg),
        .root  (root_core)
    );

    // Side data travels alongside the arithmetic stages.
    logic               vld_core_reg [0:LAT-1];
    logic signed [15:0] x_core_reg   [0:LAT-1];
    logic               ok_core_reg  [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_core_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_core_reg[0] <= vld_a_reg;
            for (int i = 1; i < LAT; i++)
                vld_core_reg[i] <= vld_core_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_core_reg[0]  <= x_a_reg;
            ok_core_reg[0] <= ok_a_reg;
            for (int i = 1; i < LAT; i++)
            begin
                x_core_reg[i]  <= x_core_reg[i-1];
                ok_core_reg[i] <= ok_core_reg[i-1];
            end
        end
    end

    // Stage B: vertical blend factor and the horizontal product.
    logic [16:0]        s_inv;
    logic [31:0]        f_prod;
    logic [15:0]        f_next;
    logic signed [32:0] xp_next;

    assign s_inv   = 17'h10000 - root_core;
    assign f_prod  = 32'(s_inv) * 32'(p3d_pkg::Y_SPAN_Q16) + 32'd32768;
    assign f_next  = 16'(17'd32768 + 17'(f_prod[31:16]));
    // The product of a 16-bit position and a scale below 2^16 always fits in 32 signed bits.
    assign xp_next = 33'(32'(x_core_reg[LAT-1]) * 32'($signed({1'b0, scale_core})));

    logic               vld_b_reg;
    logic               ok_b_reg;
    logic [15:0]        f_b_reg;
    logic signed [32:0] xp_b_reg;
    logic [15:0]        scale_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_b_reg <= 1'b0;
        else if (en)
            vld_b_reg <= vld_core_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_b_reg    <= ok_core_reg[LAT-1];
            f_b_reg     <= f_next;
            xp_b_reg    <= xp_next;
            scale_b_reg <= scale_core;
        end
    end

    // Stage C: scale to screen height and width.
    logic [27:0]        y_prod;
    logic signed [32:0] xp_round;
    logic signed [24:0] sx_next;

    assign y_prod   = 28'(height_reg) * 28'(f_b_reg) + 28'd2048;
    assign xp_round = xp_b_reg + 33'sd256;
    assign sx_next  = 25'(xp_round >>> 9) + $signed({10'b0, width_reg, 3'b0});

    logic               vld_c_reg;
    logic               ok_c_reg;
    logic [15:0]        y_c_reg;
    logic signed [24:0] sx_c_reg;
    logic [15:0]        scale_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_c_reg <= 1'b0;
        else if (en)
            vld_c_reg <= vld_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_c_reg    <= ok_b_reg;
            y_c_reg     <= y_prod[27:12];
            sx_c_reg    <= sx_next;
            scale_c_reg <= scale_b_reg;
        end
    end

    // Stage D: bounds checks, and culled objects give an all-zero result.
    logic signed [24:0] x_max;
    logic               vis;
    p3d_pkg::out_t      out_next;

    assign x_max = $signed({8'b0, ({1'b0, width_reg} + 13'd100), 4'b0});

    always_comb
    begin
        vis = (scale_c_reg >= p3d_pkg::SCALE_MIN) && (scale_c_reg <= p3d_pkg::SCALE_MAX)
            && (23'(y_c_reg) * 23'd100 >= 23'(height_reg) * 23'd720)
            && (y_c_reg <= {height_reg, 4'b0})
            && (sx_c_reg >= p3d_pkg::X_MIN) && (sx_c_reg <= x_max);
        if (ok_c_reg)
        begin
            out_next.visible    = vis;
            out_next.screen_x   = sx_c_reg[23:0];
            out_next.screen_y   = y_c_reg;
            out_next.size_scale = scale_c_reg;
        end
        else
        begin
            out_next = '0;
        end
    end

    logic          out_valid_reg;
    p3d_pkg::out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/p3d_checker.sv =====
// Port-level checks for the pseudo-3D sprite projection block, bound to its top level.
// Depends on p3d_pkg and pseudo3d_sprite_projection.
module p3d_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_stall,
    input  logic           out_valid,
    input  logic           out_stall,
    input  p3d_pkg::out_t  out_data
);

    // A held result keeps its beat.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // Input is held off exactly when a finished result is waiting.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output register");

    // An object in depth range always has a non-zero scale, so zero scale means culled.
    a_cull: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.size_scale == 16'd0 |->
            out_data.screen_x == 24'd0 && out_data.screen_y == 16'd0 && !out_data.visible)
        else $error("culled result is not all zero");

    a_vis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.visible |->
            out_data.size_scale >= p3d_pkg::SCALE_MIN && out_data.size_scale <= p3d_pkg::SCALE_MAX)
        else $error("visible result with scale out of range");

endmodule

bind pseudo3d_sprite_projection p3d_checker u_p3d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
